@@ rtl/gnpm_pkg.sv @@
// Shared constants, types and codes for the greedy nearest point matcher.
package gnpm_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 20;

    localparam int DIST_BITS = 20;
    localparam int SQ_BITS   = 2 * DIST_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int WIDE_BITS = 34;
    localparam int CMD_BITS  = 2;
    localparam int IDX_OUT_BITS = 8;
    localparam int REG_ADDR_BITS = 2;

    localparam logic [DIST_BITS-1:0] FAR_LIMIT = DIST_BITS'(999900);
    localparam int NO_INDEX = 999;

    localparam logic [REG_ADDR_BITS-1:0] REG_MAX_DIST = 2'd0;
    localparam logic [REG_ADDR_BITS-1:0] REG_SHOWER_X = 2'd1;
    localparam logic [REG_ADDR_BITS-1:0] REG_SHOWER_Y = 2'd2;
    localparam logic [REG_ADDR_BITS-1:0] REG_SHOWER_Z = 2'd3;

    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TRAJ  = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_RSVD  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic shift;
        logic clr_used;
    } cell_ctl_t;

endpackage

@@ rtl/greedy_nearest_point_matcher.sv @@
// Greedy nearest point matcher top level: command decode, cell ring and scan control.
// Clear and load transactions give no result.
// A trajectory transaction that is the track start or is skipped gives its result without a ring scan.
// A searched trajectory transaction rotates the ring once, one cell a cycle.
// Reset empties the table, clears all used marks and arms the track start capture.
module greedy_nearest_point_matcher #(
    parameter int MAX_POINTS = gnpm_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = gnpm_pkg::COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_tdata,  // pos_x, pos_y, pos_z
    input  logic [2:0]                              s_tuser,  // cmd, no_point
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [gnpm_pkg::IDX_OUT_BITS-1:0]       m_tdata,  // point_index
    output logic                                    m_tuser,  // matched
    input  logic                                    cfg_we,
    input  logic [gnpm_pkg::REG_ADDR_BITS-1:0]      cfg_addr,
    input  logic [((COORD_BITS > 20) ? COORD_BITS : 20)-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW    = 3 * COORD_BITS;
    localparam int DW    = PW + 1;
    localparam int DB    = gnpm_pkg::DIST_BITS;

    gnpm_pkg::state_t      state_reg, state_next;
    logic [IDX_W-1:0]      k_reg;
    logic [1:0]            drain_reg;
    logic [IDX_W:0]        count_reg;
    logic                  await_reg;
    logic [PW-1:0]         track_reg;
    logic [PW-1:0]         query_reg;
    logic [DB-1:0]         maxd_reg;
    logic [PW-1:0]         shower_reg;
    logic                  res_match_reg;
    logic [gnpm_pkg::IDX_OUT_BITS-1:0] res_idx_reg;
    logic                  m_valid_reg;
    logic                  m_match_reg;
    logic [gnpm_pkg::IDX_OUT_BITS-1:0] m_idx_reg;

    logic [1:0]            cmd;
    logic                  no_point;
    logic [PW-1:0]         pos;
    logic                  acc;
    logic                  acc_load;
    logic                  acc_clear;
    logic                  acc_traj;
    logic                  skip;
    logic                  scan_last;
    logic                  finish;
    logic                  out_take;
    logic                  hit;
    logic                  found;
    logic [IDX_W-1:0]      best_idx;
    logic [DB-1:0]         lim;
    logic                  feed_vld;
    gnpm_pkg::cell_ctl_t   ctl;
    logic [DW-1:0]         cq [MAX_POINTS];

    assign cmd      = s_tuser[1:0];
    assign no_point = s_tuser[2];
    assign pos      = s_tdata[PW-1:0];
    assign s_tready = (state_reg == gnpm_pkg::ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign acc_clear = acc && (cmd == gnpm_pkg::CMD_CLEAR);
    assign acc_load  = acc && (cmd == gnpm_pkg::CMD_LOAD) && (count_reg < (IDX_W+1)'(MAX_POINTS));
    assign acc_traj  = acc && (cmd == gnpm_pkg::CMD_TRAJ);
    assign skip      = await_reg || no_point || (pos == track_reg) || (pos == shower_reg);
    assign scan_last = (k_reg == IDX_W'(MAX_POINTS - 1));
    assign finish    = (state_reg == gnpm_pkg::ST_DRAIN) && (drain_reg == 2'd2);
    assign hit       = found && (32'(best_idx) != 32'(gnpm_pkg::NO_INDEX));
    assign out_take  = (state_reg == gnpm_pkg::ST_OUT) && (!m_valid_reg || m_tready);
    assign lim       = (maxd_reg < gnpm_pkg::FAR_LIMIT) ? maxd_reg : gnpm_pkg::FAR_LIMIT;
    assign feed_vld  = (state_reg == gnpm_pkg::ST_SCAN) && ({1'b0, k_reg} < count_reg)
                     && !cq[0][DW-1];
    assign ctl.shift    = (state_reg == gnpm_pkg::ST_SCAN);
    assign ctl.clr_used = acc_clear;

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
        gnpm_cell #(.DW(DW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .load_en   (acc_load && (count_reg[IDX_W-1:0] == IDX_W'(i))),
            .load_data (pos),
            .mark_en   (finish && hit && (best_idx == IDX_W'(i))),
            .nb_in     (cq[(i + 1) % MAX_POINTS]),
            .q         (cq[i])
        );
    end

    gnpm_dist #(.CB(COORD_BITS), .IDX_W(IDX_W)) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (acc_traj && !skip),
        .lim      (lim),
        .feed_vld (feed_vld),
        .feed_idx (k_reg),
        .cand     (cq[0][PW-1:0]),
        .query    (query_reg),
        .found    (found),
        .best_idx (best_idx)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gnpm_pkg::ST_IDLE: begin
                if (acc_traj) begin
                    state_next = skip ? gnpm_pkg::ST_OUT : gnpm_pkg::ST_SCAN;
                end
            end
            gnpm_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = gnpm_pkg::ST_DRAIN;
                end
            end
            gnpm_pkg::ST_DRAIN: begin
                if (finish) begin
                    state_next = gnpm_pkg::ST_OUT;
                end
            end
            gnpm_pkg::ST_OUT: begin
                if (out_take) begin
                    state_next = gnpm_pkg::ST_IDLE;
                end
            end
            default: state_next = gnpm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gnpm_pkg::ST_IDLE;
            k_reg       <= '0;
            drain_reg   <= '0;
            count_reg   <= '0;
            await_reg   <= 1'b1;
            track_reg   <= '0;
            maxd_reg    <= '0;
            shower_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= (state_reg == gnpm_pkg::ST_SCAN) ? k_reg + 1'b1 : '0;
            drain_reg <= (state_reg == gnpm_pkg::ST_DRAIN) ? drain_reg + 2'd1 : 2'd0;
            if (acc_clear) begin
                count_reg <= '0;
                await_reg <= 1'b1;
            end else if (acc_load) begin
                count_reg <= count_reg + 1'b1;
            end
            if (acc_traj && await_reg) begin
                track_reg <= pos;
                await_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    gnpm_pkg::REG_MAX_DIST: maxd_reg <= cfg_wdata[DB-1:0];
                    gnpm_pkg::REG_SHOWER_X: shower_reg[0*COORD_BITS +: COORD_BITS]
                                                <= cfg_wdata[COORD_BITS-1:0];
                    gnpm_pkg::REG_SHOWER_Y: shower_reg[1*COORD_BITS +: COORD_BITS]
                                                <= cfg_wdata[COORD_BITS-1:0];
                    gnpm_pkg::REG_SHOWER_Z: shower_reg[2*COORD_BITS +: COORD_BITS]
                                                <= cfg_wdata[COORD_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_traj) begin
            query_reg     <= pos;
            res_match_reg <= 1'b0;
            res_idx_reg   <= '0;
        end else if (finish) begin
            res_match_reg <= hit;
            res_idx_reg   <= hit ? gnpm_pkg::IDX_OUT_BITS'(best_idx) : '0;
        end
        if (out_take) begin
            m_match_reg <= res_match_reg;
            m_idx_reg   <= res_idx_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_idx_reg;
    assign m_tuser  = m_match_reg;

endmodule

@@ rtl/gnpm_cell.sv @@
// One ring cell: holds a stored point and its used mark, passes both to its neighbor.
module gnpm_cell #(
    parameter int DW = 61
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  gnpm_pkg::cell_ctl_t ctl,
    input  logic               load_en,
    input  logic [DW-2:0]      load_data,
    input  logic               mark_en,
    input  logic [DW-1:0]      nb_in,
    output logic [DW-1:0]      q
);

    logic [DW-2:0] pt_reg;
    logic          used_reg;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            pt_reg <= nb_in[DW-2:0];
        end else if (load_en) begin
            pt_reg <= load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctl.shift) begin
            used_reg <= nb_in[DW-1];
        end else if (ctl.clr_used || load_en) begin
            used_reg <= 1'b0;
        end else if (mark_en) begin
            used_reg <= 1'b1;
        end
    end

    assign q = {used_reg, pt_reg};

endmodule

@@ rtl/gnpm_dist.sv @@
// Squared distance pipeline and running nearest-candidate search.
module gnpm_dist #(
    parameter int CB    = 20,
    parameter int IDX_W = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [gnpm_pkg::DIST_BITS-1:0] lim,
    input  logic                           feed_vld,
    input  logic [IDX_W-1:0]               feed_idx,
    input  logic [3*CB-1:0]                cand,
    input  logic [3*CB-1:0]                query,
    output logic                           found,
    output logic [IDX_W-1:0]               best_idx
);

    localparam int WB = gnpm_pkg::WIDE_BITS;
    localparam int DB = gnpm_pkg::DIST_BITS;

    logic [DB-1:0]                    abs_c [3];
    logic [2:0]                       far_c;
    logic [DB-1:0]                    s1_abs_reg [3];
    logic                             s1_far_reg;
    logic                             s1_vld_reg;
    logic [IDX_W-1:0]                 s1_idx_reg;
    logic [gnpm_pkg::SQ_BITS-1:0]     s2_sq_reg [3];
    logic                             s2_vld_reg;
    logic [IDX_W-1:0]                 s2_idx_reg;
    logic [gnpm_pkg::SUM_BITS-1:0]    sum;
    logic [gnpm_pkg::SQ_BITS-1:0]     lim_sq;
    logic [gnpm_pkg::SUM_BITS-1:0]    best_reg;
    logic                             found_reg;
    logic [IDX_W-1:0]                 best_idx_reg;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [CB-1:0] cv;
        logic signed [CB-1:0] qv;
        logic signed [WB-1:0] diff;
        logic [WB-1:0]        mag;
        assign cv    = cand[a*CB +: CB];
        assign qv    = query[a*CB +: CB];
        assign diff  = WB'(cv) - WB'(qv);
        assign mag   = diff[WB-1] ? WB'(-diff) : WB'(diff);
        assign far_c[a] = |mag[WB-1:DB];
        assign abs_c[a] = mag[DB-1:0];
    end

    always_ff @(posedge aclk) begin
        s1_abs_reg <= abs_c;
        s1_far_reg <= |far_c;
        s1_idx_reg <= feed_idx;
        for (int a = 0; a < 3; a++) begin
            s2_sq_reg[a] <= s1_abs_reg[a] * s1_abs_reg[a];
        end
        s2_idx_reg <= s1_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= feed_vld;
            s2_vld_reg <= s1_vld_reg && !s1_far_reg;
        end
    end

    assign sum = gnpm_pkg::SUM_BITS'(s2_sq_reg[0]) + gnpm_pkg::SUM_BITS'(s2_sq_reg[1])
               + gnpm_pkg::SUM_BITS'(s2_sq_reg[2]);

    assign lim_sq = lim * lim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (start) begin
            found_reg <= 1'b0;
        end else if (s2_vld_reg && (sum < best_reg)) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            best_reg <= gnpm_pkg::SUM_BITS'(lim_sq);
        end else if (s2_vld_reg && (sum < best_reg)) begin
            best_reg     <= sum;
            best_idx_reg <= s2_idx_reg;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule
